/* sv/imuah_pkg.sv */
package imuah_pkg;

	localparam int unsigned NAXES       = 9;
	localparam int unsigned AXIS_W      = 16;
	localparam int unsigned TS_W        = 32;
	localparam int unsigned INTV_W      = 16;
	localparam int unsigned DECL_W      = 15;
	localparam int unsigned HEAD_W      = 17;
	localparam int unsigned CFG_IDX_W   = 4;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 4;

	// stream layouts
	localparam int unsigned IN_TDATA_W   = 192;
	localparam int unsigned IN_AXIS_LSB  = 32;
	localparam int unsigned IN_TEMP_LSB  = 176;
	localparam int unsigned OUT_TDATA_W  = 184;
	localparam int unsigned OUT_HEAD_LSB = 144;
	localparam int unsigned OUT_TEMP_LSB = 161;

	// heading arithmetic, angles in 1/256 centidegree
	localparam int unsigned MAG_SHIFT = 24;
	localparam int unsigned ANG_W     = 25;
	localparam int unsigned ROUND_SH  = 8;
	localparam int unsigned CDEG_W    = 16;
	localparam logic signed [ANG_W-1:0] DEG180     = 25'sd4608000;
	localparam logic signed [ANG_W-1:0] ROUND_HALF = 25'sd128;
	localparam logic signed [ANG_W-1:0] DEG360_RND = 25'sd9216128;
	localparam logic [CDEG_W-1:0]       FULL_TURN  = 16'd36000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_INTERVAL = 4'd0,
		REG_DECLINATION     = 4'd1
	} reg_idx_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:    v = 25'sd1152000;
			5'd1:    v = 25'sd680065;
			5'd2:    v = 25'sd359328;
			5'd3:    v = 25'sd182400;
			5'd4:    v = 25'sd91554;
			5'd5:    v = 25'sd45822;
			5'd6:    v = 25'sd22916;
			5'd7:    v = 25'sd11459;
			5'd8:    v = 25'sd5730;
			5'd9:    v = 25'sd2865;
			5'd10:   v = 25'sd1432;
			5'd11:   v = 25'sd716;
			5'd12:   v = 25'sd358;
			5'd13:   v = 25'sd179;
			5'd14:   v = 25'sd90;
			5'd15:   v = 25'sd45;
			5'd16:   v = 25'sd22;
			5'd17:   v = 25'sd11;
			5'd18:   v = 25'sd6;
			5'd19:   v = 25'sd3;
			5'd20:   v = 25'sd1;
			5'd21:   v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

endpackage

/* sv/imuah_front.sv */
module imuah_front #(
	parameter int unsigned N     = 8,
	parameter int unsigned SUM_W = 19,
	parameter int unsigned REC_W = 187
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// timestamp_ms, accel_x/y/z, gyro_x/y/z, mag_x/y/z, temp_raw
	input  logic [imuah_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic [imuah_pkg::INTV_W-1:0]          interval,
	input  logic                                  q_full,
	output logic                                  q_push,
	output logic [REC_W-1:0]                      q_data
);

	localparam int unsigned CNT_W = (N > 1) ? $clog2(N) : 1;

	logic signed [SUM_W-1:0] sums_q [imuah_pkg::NAXES];
	logic signed [SUM_W-1:0] sums_nx [imuah_pkg::NAXES];
	logic [CNT_W-1:0] count_q;
	logic [imuah_pkg::TS_W-1:0] last_q;
	logic [imuah_pkg::TS_W-1:0] ts;
	logic [imuah_pkg::TS_W-1:0] dt;
	logic signed [imuah_pkg::AXIS_W-1:0] axis_in [imuah_pkg::NAXES];
	logic take;
	logic done;

	assign s_axis_tready = !q_full;
	assign ts = s_axis_tdata[imuah_pkg::TS_W-1:0];
	assign dt = ts - last_q;
	assign take = s_axis_tvalid && s_axis_tready
		&& (dt >= imuah_pkg::TS_W'(interval));
	assign done = take && (count_q == CNT_W'(N - 1));
	assign q_push = done;

	always_comb begin
		for (int k = 0; k < imuah_pkg::NAXES; k++) begin
			axis_in[k] = $signed(s_axis_tdata[imuah_pkg::IN_AXIS_LSB
				+ imuah_pkg::AXIS_W * k +: imuah_pkg::AXIS_W]);
			sums_nx[k] = sums_q[k] + SUM_W'(axis_in[k]);
		end
	end

	// record: nine sums from the lowest bits, then temperature
	always_comb begin
		q_data = '0;
		for (int k = 0; k < imuah_pkg::NAXES; k++) begin
			q_data[SUM_W * k +: SUM_W] = sums_nx[k];
		end
		q_data[SUM_W * imuah_pkg::NAXES +: imuah_pkg::AXIS_W] =
			s_axis_tdata[imuah_pkg::IN_TEMP_LSB +: imuah_pkg::AXIS_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
			for (int k = 0; k < imuah_pkg::NAXES; k++) begin
				sums_q[k] <= '0;
			end
		end else if (take) begin
			last_q <= ts;
			if (done) begin
				count_q <= '0;
				for (int k = 0; k < imuah_pkg::NAXES; k++) begin
					sums_q[k] <= '0;
				end
			end else begin
				count_q <= count_q + CNT_W'(1);
				for (int k = 0; k < imuah_pkg::NAXES; k++) begin
					sums_q[k] <= sums_nx[k];
				end
			end
		end
	end

endmodule

/* sv/imuah_queue.sv */
module imuah_queue #(
	parameter int unsigned WIDTH = 187,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("queue read while empty");

endmodule

/* sv/imuah_back.sv */
module imuah_back #(
	parameter int unsigned N     = 8,
	parameter int unsigned STEPS = 16,
	parameter int unsigned SUM_W = 19,
	parameter int unsigned REC_W = 187
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	output logic                                  q_pop,
	input  logic [REC_W-1:0]                      q_data,
	input  logic signed [imuah_pkg::DECL_W-1:0]   decl,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// accel_avg_x/y/z, gyro_avg_x/y/z, mag_avg_x/y/z, heading_centideg, temp_latest
	output logic [imuah_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int unsigned NA    = imuah_pkg::NAXES;
	localparam int unsigned AW    = imuah_pkg::AXIS_W;
	localparam int unsigned ZW    = imuah_pkg::ANG_W;
	localparam int unsigned LOGN  = $clog2(N);
	localparam int unsigned K     = SUM_W + LOGN;
	localparam int unsigned R_W   = SUM_W + 1;
	localparam int unsigned P_W   = SUM_W + R_W;
	localparam int unsigned CW    = SUM_W + imuah_pkg::MAG_SHIFT + 2;
	localparam int unsigned AVG_N = STEPS - 1;
	localparam logic [63:0] RECIP_FULL = ((64'd1 << K) + 64'(N) - 64'd1) / 64'(N);
	localparam logic [R_W-1:0] RECIP = RECIP_FULL[R_W-1:0];

	logic adv;

	logic signed [SUM_W-1:0] sum_in [NA];
	logic signed [CW-1:0] ix;
	logic signed [CW-1:0] iy;
	logic negx;

	// divide by the block length via reciprocal multiply
	logic [SUM_W-1:0] mag_s1 [NA];
	logic [NA-1:0] neg_s1;
	logic [P_W-1:0] prod_s2 [NA];
	logic [NA-1:0] neg_s2;
	logic [AW-1:0] avg_s [AVG_N][NA];

	// vectoring rotations, index k sits at stage k+1
	logic signed [CW-1:0] cx_s [STEPS+1];
	logic signed [CW-1:0] cy_s [STEPS+1];
	logic signed [ZW-1:0] cz_s [STEPS+1];
	logic [AW-1:0] temp_s [STEPS+1];
	logic [STEPS:0] zero_s;
	logic [STEPS:0] v_s;

	logic signed [ZW-1:0] fold_z_s;
	logic [AW-1:0] fold_avg_s [NA];
	logic [AW-1:0] fold_temp_s;
	logic fold_zero_s;
	logic fold_v_s;

	logic [imuah_pkg::CDEG_W-1:0] head_c;
	logic [imuah_pkg::CDEG_W-1:0] head_w;

	logic out_valid_q;
	logic [AW-1:0] avg_q [NA];
	logic [imuah_pkg::HEAD_W-1:0] head_q;
	logic [AW-1:0] temp_q;

	assign adv = !out_valid_q || m_axis_tready;
	assign q_pop = adv && q_valid;

	always_comb begin
		for (int k = 0; k < NA; k++) begin
			sum_in[k] = $signed(q_data[SUM_W * k +: SUM_W]);
		end
	end

	assign ix = CW'(sum_in[6]) <<< imuah_pkg::MAG_SHIFT;
	assign iy = CW'(sum_in[7]) <<< imuah_pkg::MAG_SHIFT;
	assign negx = sum_in[6][SUM_W-1];

	assign head_c = fold_z_s[imuah_pkg::ROUND_SH +: imuah_pkg::CDEG_W];
	always_comb begin
		if (fold_zero_s) begin
			head_w = '0;
		end else if (head_c >= imuah_pkg::FULL_TURN) begin
			head_w = head_c - imuah_pkg::FULL_TURN;
		end else begin
			head_w = head_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NA; k++) begin
				neg_s1[k] <= sum_in[k][SUM_W-1];
				mag_s1[k] <= sum_in[k][SUM_W-1] ? SUM_W'(-sum_in[k]) : SUM_W'(sum_in[k]);
				prod_s2[k] <= P_W'(mag_s1[k]) * P_W'(RECIP);
				avg_s[0][k] <= neg_s2[k] ? AW'(17'd0 - prod_s2[k][P_W-1:K])
					: prod_s2[k][K +: AW];
			end
			neg_s2 <= neg_s1;
			for (int j = 1; j < AVG_N; j++) begin
				avg_s[j] <= avg_s[j-1];
			end

			cx_s[0]   <= negx ? -ix : ix;
			cy_s[0]   <= negx ? -iy : iy;
			cz_s[0]   <= negx ? imuah_pkg::DEG180 : '0;
			temp_s[0] <= q_data[SUM_W * NA +: AW];
			zero_s[0] <= (sum_in[6] == '0) && (sum_in[7] == '0);
			for (int k = 0; k < STEPS; k++) begin
				if (!cy_s[k][CW-1]) begin
					cx_s[k+1] <= cx_s[k] + (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] - (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] + imuah_pkg::atan_entry(5'(k));
				end else begin
					cx_s[k+1] <= cx_s[k] - (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] + (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] - imuah_pkg::atan_entry(5'(k));
				end
				temp_s[k+1] <= temp_s[k];
				zero_s[k+1] <= zero_s[k];
			end

			// fold to a positive angle and add the rounding half
			fold_z_s <= cz_s[STEPS] + (cz_s[STEPS][ZW-1] ? imuah_pkg::DEG360_RND
				: imuah_pkg::ROUND_HALF);
			fold_avg_s  <= avg_s[AVG_N-1];
			fold_temp_s <= temp_s[STEPS];
			fold_zero_s <= zero_s[STEPS];

			avg_q  <= fold_avg_s;
			temp_q <= fold_temp_s;
			head_q <= {1'b0, head_w} + imuah_pkg::HEAD_W'(decl);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s         <= '0;
			fold_v_s    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s         <= {v_s[STEPS-1:0], q_pop};
			fold_v_s    <= v_s[STEPS];
			out_valid_q <= fold_v_s;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		m_axis_tdata = '0;
		for (int k = 0; k < NA; k++) begin
			m_axis_tdata[AW * k +: AW] = avg_q[k];
		end
		m_axis_tdata[imuah_pkg::OUT_HEAD_LSB +: imuah_pkg::HEAD_W] = head_q;
		m_axis_tdata[imuah_pkg::OUT_TEMP_LSB +: AW] = temp_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fold_v_s |-> !fold_z_s[ZW-1] && (fold_z_s < imuah_pkg::DEG360_RND))
		else $error("folded heading angle out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fold_v_s))
		else $error("result appeared without a request in the fold stage");

endmodule

/* sv/imu_block_average_heading.sv */
// imu_block_average_heading
// Input stream (s_axis_*) takes one IMU sample per request: timestamp, nine
// 16-bit axes and temperature. A sample closer than sample_interval_ms to the
// last accepted one is dropped. Every SAMPLES_PER_AVERAGE accepted samples the
// output stream (m_axis_*) gives one request: nine block averages truncated
// toward zero, the magnetic heading in centidegrees plus declination, and the
// temperature of the completing sample.
// Throughput: one sample per cycle while the queue is not full. The accumulator
// hands completed blocks to a four-entry queue; the heading unit is a
// CORDIC_STEPS deep rotation pipeline, and a block passes the queue, the input
// stage, the rotation stages, the fold stage and the output register in turn.
// Configuration (cfg_*) is always ready; index 0 is the sample interval,
// index 1 the declination, other indexes are ignored. Write only while idle.
// Reset clears sums, sample count, last accept time (to zero) and restores
// the registers (interval 10, declination 0). If m_axis_tready stays low the
// output holds, the pipeline stops, the queue fills and s_axis_tready drops
// once four completed blocks are waiting.
module imu_block_average_heading #(
	parameter int unsigned SAMPLES_PER_AVERAGE = 8,
	parameter int unsigned CORDIC_STEPS        = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// timestamp_ms, accel_x/y/z, gyro_x/y/z, mag_x/y/z, temp_raw
	input  logic [imuah_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// accel_avg_x/y/z, gyro_avg_x/y/z, mag_avg_x/y/z, heading_centideg, temp_latest
	output logic [imuah_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imuah_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imuah_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned SUM_W = imuah_pkg::AXIS_W + $clog2(SAMPLES_PER_AVERAGE);
	localparam int unsigned REC_W = SUM_W * imuah_pkg::NAXES + imuah_pkg::AXIS_W;

	logic [imuah_pkg::INTV_W-1:0] interval_q;
	logic signed [imuah_pkg::DECL_W-1:0] decl_q;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	logic [REC_W-1:0] push_data;
	logic [REC_W-1:0] pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 16'd10;
			decl_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				imuah_pkg::REG_SAMPLE_INTERVAL: interval_q <= cfg_data;
				imuah_pkg::REG_DECLINATION:     decl_q <= cfg_data[imuah_pkg::DECL_W-1:0];
				default: ;
			endcase
		end
	end

	imuah_front #(
		.N     (SAMPLES_PER_AVERAGE),
		.SUM_W (SUM_W),
		.REC_W (REC_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.interval      (interval_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	imuah_queue #(
		.WIDTH (REC_W),
		.DEPTH (imuah_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	imuah_back #(
		.N     (SAMPLES_PER_AVERAGE),
		.STEPS (CORDIC_STEPS),
		.SUM_W (SUM_W),
		.REC_W (REC_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_data        (pop_data),
		.decl          (decl_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
